>>> sv/plam_pkg.sv
`timescale 1ns / 1ps
// Package for polyline_arc_length_midpoint: sequencer states and the FRAC_BITS constant.
// No dependencies.
package plam_pkg;

    localparam int FRAC_BITS = 28;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_SEG,
        ST_FIN,
        ST_WRD,
        ST_WCMP,
        ST_PA,
        ST_PB,
        ST_PC,
        ST_DIV,
        ST_MULI,
        ST_OUT
    } state_t;

endpackage

>>> sv/polyline_arc_length_midpoint.sv
`timescale 1ns / 1ps
// Polyline arc-length midpoint: bit-serial segment length, walk and interpolation.
// Depends on plam_pkg.
//
// Channel   Dir  Signals                        Payload
// s_        in   tvalid tready tdata tuser tlast  {vertex_y, vertex_x}, has_point, last_point
// m_        out  tvalid tready tdata tuser        {mid_y, mid_x}, {overflowed, empty_path}
//
// Vertex transfer: serial squares, then one root bit a cycle.
// Last transfer adds a walk over the segments, then the serial divide and serial interpolation multiply.
// Reset: aresetn synchronous, active low; vertex memories are not cleared.
// s_tready is high only while idle; a held result does not block vertex loading.
module polyline_arc_length_midpoint
    import plam_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 24
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // vertex_x, vertex_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    // has_point
    input  logic                                      s_tuser,
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // mid_x, mid_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_tdata,
    // empty_path, overflowed
    output logic [1:0]                                m_tuser
);

    localparam int C     = COORD_BITS;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CW    = AW + 1;
    localparam int DW    = C + 1;
    localparam int SEGW  = C + 1;
    localparam int SQW   = 2 * C + 2;
    localparam int TOTW  = SEGW + AW;
    localparam int DVW   = SEGW + 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int PW    = DW + QW;
    localparam int CNTW  = $clog2(SQW + QW);
    localparam int DATAW = ((2 * C + 7) / 8) * 8;

    logic signed [C-1:0] mem_x [MAX_VERTICES];
    logic signed [C-1:0] mem_y [MAX_VERTICES];
    logic [SEGW-1:0]     mem_s [MAX_VERTICES];

    state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [TOTW-1:0] total_reg, total_next;
    logic            ovf_reg, ovf_next;
    logic            last_reg, last_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic signed [C-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [DW-1:0]   mx_reg, mx_next, my_reg, my_next;
    logic [DW-1:0]   bx_reg, bx_next, by_reg, by_next;
    logic [SQW-1:0]  px_reg, px_next, py_reg, py_next;
    logic [SQW-1:0]  rad_reg, rad_next;
    logic [SEGW-1:0] root_reg, root_next;
    logic [DVW-1:0]  rem_reg, rem_next;
    logic [AW-1:0]   seg_addr_reg, seg_addr_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [TOTW-1:0] acc_reg, acc_next;
    logic [SEGW-1:0] seg_reg, seg_next;
    logic            zero_reg, zero_next;
    logic [DVW-1:0]  need_reg, need_next;
    logic signed [C-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic            nx_reg, nx_next, ny_reg, ny_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [PW-1:0]   ix_reg, ix_next, iy_reg, iy_next;
    logic signed [C-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic            res_e_reg, res_e_next;
    logic            mv_reg, mv_next;
    logic signed [C-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic            oe_reg, oe_next, oo_reg, oo_next;

    logic            s_acc;
    logic signed [C-1:0] in_x, in_y;
    logic            wr_v, wr_s;
    logic [AW-1:0]   rd_addr;
    logic signed [C-1:0] x_rd_reg, y_rd_reg;
    logic [SEGW-1:0] s_rd_reg;

    logic signed [DW-1:0] ddx, ddy;
    logic [DVW-1:0]  pr_t, trial;
    logic [TOTW:0]   accseg;
    logic [DVW-1:0]  dvs, rsub;
    logic            ge;
    logic [PW:0]     rx, ry;
    logic [DW-1:0]   offx, offy;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_x     = s_tdata[C-1:0];
    assign in_y     = s_tdata[2*C-1:C];
    assign m_tvalid = mv_reg;
    assign m_tdata  = DATAW'({oy_reg, ox_reg});
    assign m_tuser  = {oo_reg, oe_reg};

    always_ff @(posedge aclk) begin
        if (wr_v) begin
            mem_x[count_reg[AW-1:0]] <= in_x;
            mem_y[count_reg[AW-1:0]] <= in_y;
        end
        if (wr_s) begin
            mem_s[seg_addr_reg] <= root_reg;
        end
        x_rd_reg <= mem_x[rd_addr];
        y_rd_reg <= mem_y[rd_addr];
        s_rd_reg <= mem_s[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            mv_reg    <= mv_next;
        end
        last_reg     <= last_next;
        cnt_reg      <= cnt_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        seg_addr_reg <= seg_addr_next;
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        seg_reg      <= seg_next;
        zero_reg     <= zero_next;
        need_reg     <= need_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        q_reg        <= q_next;
        ix_reg       <= ix_next;
        iy_reg       <= iy_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_e_reg    <= res_e_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        oe_reg       <= oe_next;
        oo_reg       <= oo_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        rad_next      = rad_reg;
        root_next     = root_reg;
        rem_next      = rem_reg;
        seg_addr_next = seg_addr_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        seg_next      = seg_reg;
        zero_next     = zero_reg;
        need_next     = need_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        q_next        = q_reg;
        ix_next       = ix_reg;
        iy_next       = iy_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_e_next    = res_e_reg;
        mv_next       = mv_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oe_next       = oe_reg;
        oo_next       = oo_reg;
        wr_v          = 1'b0;
        wr_s          = 1'b0;
        rd_addr       = idx_reg;

        ddx    = DW'(in_x) - DW'(prev_x_reg);
        ddy    = DW'(in_y) - DW'(prev_y_reg);
        pr_t   = {rem_reg[SEGW-1:0], rad_reg[SQW-1 -: 2]};
        trial  = {root_reg, 2'b01};
        accseg = (TOTW + 1)'(acc_reg) + (TOTW + 1)'(s_rd_reg);
        dvs    = DVW'({seg_reg, 1'b0});
        ge     = (rem_reg >= dvs);
        rsub   = ge ? (rem_reg - dvs) : rem_reg;
        rx     = (PW + 1)'(ix_reg) + (PW + 1)'(1 << (FRAC_BITS - 1));
        ry     = (PW + 1)'(iy_reg) + (PW + 1)'(1 << (FRAC_BITS - 1));
        offx   = rx[FRAC_BITS +: DW];
        offy   = ry[FRAC_BITS +: DW];

        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    last_next = s_tlast;
                    state_next = s_tlast ? ST_FIN : ST_IDLE;
                    if (s_tuser) begin
                        if (count_reg < CW'(MAX_VERTICES)) begin
                            wr_v        = 1'b1;
                            count_next  = count_reg + 1'b1;
                            prev_x_next = in_x;
                            prev_y_next = in_y;
                            if (count_reg != '0) begin
                                seg_addr_next = AW'(count_reg - 1'b1);
                                mx_next    = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
                                my_next    = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
                                bx_next    = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
                                by_next    = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
                                px_next    = '0;
                                py_next    = '0;
                                cnt_next   = CNTW'(DW - 1);
                                state_next = ST_MUL;
                            end
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            ST_MUL: begin
                px_next = {px_reg[SQW-2:0], 1'b0} + (bx_reg[DW-1] ? SQW'(mx_reg) : '0);
                py_next = {py_reg[SQW-2:0], 1'b0} + (by_reg[DW-1] ? SQW'(my_reg) : '0);
                bx_next = {bx_reg[DW-2:0], 1'b0};
                by_next = {by_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (pr_t >= trial) begin
                    rem_next  = pr_t - trial;
                    root_next = {root_reg[SEGW-2:0], 1'b1};
                end else begin
                    rem_next  = pr_t;
                    root_next = {root_reg[SEGW-2:0], 1'b0};
                end
                rad_next = {rad_reg[SQW-3:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG: begin
                wr_s       = 1'b1;
                total_next = total_reg + TOTW'(root_reg);
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                idx_next = '0;
                acc_next = '0;
                if (count_reg == '0) begin
                    res_x_next = '0;
                    res_y_next = '0;
                    res_e_next = 1'b1;
                    state_next = ST_OUT;
                end else if (count_reg == CW'(1)) begin
                    zero_next  = 1'b1;
                    res_e_next = 1'b0;
                    state_next = ST_PA;
                end else begin
                    res_e_next = 1'b0;
                    state_next = ST_WRD;
                end
            end
            ST_WRD: begin
                state_next = ST_WCMP;
            end
            ST_WCMP: begin
                if ({accseg, 1'b0} >= (TOTW + 2)'(total_reg)) begin
                    seg_next   = s_rd_reg;
                    zero_next  = (s_rd_reg == '0);
                    need_next  = DVW'(total_reg - {acc_reg[TOTW-2:0], 1'b0});
                    state_next = ST_PA;
                end else begin
                    acc_next   = accseg[TOTW-1:0];
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_WRD;
                end
            end
            ST_PA: begin
                state_next = ST_PB;
            end
            ST_PB: begin
                ax_next    = x_rd_reg;
                ay_next    = y_rd_reg;
                rd_addr    = idx_reg + 1'b1;
                state_next = ST_PC;
            end
            ST_PC: begin
                ddx = DW'(x_rd_reg) - DW'(ax_reg);
                ddy = DW'(y_rd_reg) - DW'(ay_reg);
                nx_next = ddx[DW-1];
                ny_next = ddy[DW-1];
                mx_next = ddx[DW-1] ? DW'(-ddx) : DW'(ddx);
                my_next = ddy[DW-1] ? DW'(-ddy) : DW'(ddy);
                if (zero_reg) begin
                    res_x_next = ax_reg;
                    res_y_next = ay_reg;
                    state_next = ST_OUT;
                end else begin
                    rem_next   = need_reg;
                    q_next     = '0;
                    cnt_next   = CNTW'(QW - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                q_next   = {q_reg[QW-2:0], ge};
                rem_next = {rsub[DVW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    ix_next    = '0;
                    iy_next    = '0;
                    cnt_next   = CNTW'(QW - 1);
                    state_next = ST_MULI;
                end
            end
            ST_MULI: begin
                ix_next = {ix_reg[PW-2:0], 1'b0} + (q_reg[QW-1] ? PW'(mx_reg) : '0);
                iy_next = {iy_reg[PW-2:0], 1'b0} + (q_reg[QW-1] ? PW'(my_reg) : '0);
                q_next  = {q_reg[QW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    ox_next    = res_x_reg;
                    oy_next    = res_y_reg;
                    oe_next    = res_e_reg;
                    oo_next    = ovf_reg;
                    mv_next    = 1'b1;
                    count_next = '0;
                    total_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_MUL && cnt_reg == '0) begin
            rad_next  = px_next + py_next;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = CNTW'(SEGW - 1);
        end
        if (state_reg == ST_MULI && cnt_reg == '0) begin
            rx = (PW + 1)'(ix_next) + (PW + 1)'(1 << (FRAC_BITS - 1));
            ry = (PW + 1)'(iy_next) + (PW + 1)'(1 << (FRAC_BITS - 1));
            offx = rx[FRAC_BITS +: DW];
            offy = ry[FRAC_BITS +: DW];
            res_x_next = nx_reg ? C'(DW'(ax_reg) - offx) : C'(DW'(ax_reg) + offx);
            res_y_next = ny_reg ? C'(DW'(ay_reg) - offy) : C'(DW'(ay_reg) + offy);
        end
    end

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count above capacity");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WCMP |-> (CW'(idx_reg) + 1'b1) < count_reg)
        else $error("walk ran past last segment");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tdata == '0)
        else $error("empty result with nonzero point");

    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && state_next == ST_IDLE) |=> (count_reg == '0 && !ovf_reg))
        else $error("state not cleared after result");

endmodule
